// ===== src/bubble_sort_engine_core_assert.svh =====
// Assertion macros used by the checker of the sort engine.
`ifndef BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bse_pkg.sv =====
package bse_pkg;

  localparam int unsigned VALUE_W = 32;

  // One element of the set, as a signed two's complement word.
  typedef logic signed [VALUE_W-1:0] value_t;

  // Outcome of one compare-exchange step.
  typedef struct packed {
    logic   swap;
    value_t low_val;
    value_t high_val;
  } cmp_res_t;

endpackage

// ===== src/bubble_sort_engine_core.sv =====
// Sort engine: collects up to MAX_ELEMENTS signed 32-bit values, one request per
// cycle, until a request marked last closes the set; requests beyond the store
// depth are dropped and every result of that set then carries out_dropped_o.
// The set is sorted in place with bubble passes that run through one shared
// compare-exchange unit and the single read and single write port of the
// local store. Passes repeat until one makes no swap; a set of one skips
// sorting. Results then leave smallest first, each one held while the
// output is stalled, the final one marked by out_last_o. No new request is
// taken from the closing request until the final result sits in the output
// register; that result may wait there while the next set loads.
module bubble_sort_engine_core #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bse_pkg::value_t in_value_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bse_pkg::value_t out_value_o,
  output logic            out_last_o,
  output logic            out_dropped_o
);
  import bse_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          swapped_q, swapped_d;
  logic          rd_ok_q, rd_ok_d;
  value_t        carry_q, carry_d;
  value_t        rdata_q;
  logic          out_valid_q, out_valid_d;
  value_t        out_value_q;
  logic          out_last_q;
  logic          out_dropped_q;

  value_t        store_mem [MAX_ELEMENTS];
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;

  logic          in_accept;
  logic          store_full;
  logic          idx_at_end;
  logic          out_free;
  logic          out_load;
  cmp_res_t      cmp_res;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign store_full = (cnt_q >= CW'(MAX_ELEMENTS));
  assign idx_at_end = (CW'(idx_q) == (cnt_q - CW'(1)));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Shared compare-exchange unit: running maximum against the value just read.
  bse_cmp_unit u_cmp (
    .carry_i (carry_q),
    .next_i  (rdata_q),
    .res_o   (cmp_res)
  );

  // Sequencer for loading, bubble passes and draining.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    swapped_d = swapped_q;
    rd_ok_d   = rd_ok_q;
    carry_d   = carry_q;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_data   = in_value_i;
    out_load  = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
          if (in_last_i) begin
            idx_d   = '0;
            rd_ok_d = 1'b0;
            state_d = (cnt_q == '0) ? S_EMIT : S_START;
          end
        end
      end
      S_START: begin
        rd_addr   = '0;
        swapped_d = 1'b0;
        state_d   = S_FIRST;
      end
      S_FIRST: begin
        carry_d = rdata_q;
        rd_addr = AW'(1);
        idx_d   = AW'(1);
        state_d = S_RUN;
      end
      S_RUN: begin
        wr_en     = 1'b1;
        wr_addr   = idx_q - AW'(1);
        wr_data   = cmp_res.low_val;
        carry_d   = cmp_res.high_val;
        swapped_d = swapped_q | cmp_res.swap;
        if (idx_at_end) begin
          state_d = S_END;
        end else begin
          rd_addr = idx_q + AW'(1);
          idx_d   = idx_q + AW'(1);
        end
      end
      S_END: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = carry_q;
        idx_d   = '0;
        rd_ok_d = 1'b0;
        state_d = swapped_q ? S_START : S_EMIT;
      end
      S_EMIT: begin
        if (rd_ok_q && out_free) begin
          out_load = 1'b1;
          rd_ok_d  = 1'b0;
          if (idx_at_end) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + AW'(1);
            rd_addr = idx_q + AW'(1);
          end
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Output valid follows loads and completed requests.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      swapped_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      swapped_q   <= swapped_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (out_load) begin
      out_value_q   <= rdata_q;
      out_last_q    <= idx_at_end;
      out_dropped_q <= ovf_q;
    end
  end

  // Local store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rdata_q <= store_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_last_o    = out_last_q;
  assign out_dropped_o = out_dropped_q;

endmodule

// ===== src/bse_cmp_unit.sv =====
module bse_cmp_unit (
  input  bse_pkg::value_t   carry_i,
  input  bse_pkg::value_t   next_i,
  output bse_pkg::cmp_res_t res_o
);
  import bse_pkg::*;

  logic swap;

  // Swap only on strict less-than so equal values keep their arrival order.
  assign swap = (next_i < carry_i);

  // The smaller value goes back to the store, the larger travels on.
  always_comb begin
    res_o.swap     = swap;
    res_o.low_val  = swap ? next_i : carry_i;
    res_o.high_val = swap ? carry_i : next_i;
  end

endmodule

// ===== src/bse_checker.sv =====
module bse_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input bse_pkg::value_t in_value_i,
  input logic            in_last_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input bse_pkg::value_t out_value_o,
  input logic            out_last_o,
  input logic            out_dropped_o
);
  `include "bubble_sort_engine_core_assert.svh"

  // A stalled result stays offered.
  `BSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   out_valid_o && out_stall_i, out_valid_o,
                   "result withdrawn while stalled")

  // A stalled result does not change.
  `BSE_ASSERT_NEXT(a_out_stable, clk_i, rst_ni,
                   out_valid_o && out_stall_i,
                   $stable(out_value_o) && $stable(out_last_o) && $stable(out_dropped_o),
                   "stalled result changed")

  // Closing a set ends loading, so the input side goes busy.
  `BSE_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni,
                   in_valid_i && !in_stall_o && in_last_i, in_stall_o,
                   "input not busy after closing request")

  // A request that does not close the set leaves the block loading.
  `BSE_ASSERT_NEXT(a_load_continues, clk_i, rst_ni,
                   in_valid_i && !in_stall_o && !in_last_i, !in_stall_o,
                   "input stalled while loading a set")

  // An accepted request carries a fully known value and last flag.
  `BSE_ASSERT_NOW(a_in_known, clk_i, rst_ni,
                  in_valid_i && !in_stall_o, !$isunknown({in_value_i, in_last_i}),
                  "unknown request payload")

endmodule

bind bubble_sort_engine_core bse_checker u_bse_checker (.*);
